@@ src/vmd_pkg.sv @@
// Shared types and constants for the voice mixer with distance pan.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package vmd_pkg;

    // Configuration register indexes
    localparam int          CFG_INDEX_W       = 2;
    localparam logic [1:0]  CFG_MASTER_VOLUME = 2'd0;
    localparam logic [1:0]  CFG_LISTENER_X    = 2'd1;
    localparam logic [1:0]  CFG_LISTENER_Y    = 2'd2;
    localparam int          CFG_DATA_W        = 24;

    // Reset values and sizing
    localparam logic [6:0]  MASTER_RESET      = 7'd100;
    localparam int          MAX_VOICES_DEF    = 64;
    localparam int          QUEUE_DEPTH       = 2;

    // Distance range and its square
    localparam logic [10:0] RANGE             = 11'd1500;
    localparam logic [22:0] RANGE_SQ          = 23'd2250000;

    // Reciprocals: floor(x / d) == (x * M) >> S over the operand range used
    localparam logic [19:0] RECIP_RANGE       = 20'd715828;   // d = 1500, x < 2^19
    localparam int          RECIP_RANGE_SHIFT = 30;
    localparam logic [19:0] RECIP_255         = 20'd65794;    // d = 255, x <= 65025
    localparam int          RECIP_255_SHIFT   = 24;
    localparam logic [31:0] RECIP_101         = 32'd2721563436; // d = 101, x < 2^30
    localparam int          RECIP_101_SHIFT   = 38;

    // Magnitudes at or above this always clamp the output after / 101 / 256
    localparam logic [29:0] EMIT_CLAMP        = 30'd847249408;
    localparam int          ROUND_SHIFT       = 8;
    localparam logic [14:0] OUT_LIM           = 15'h7fff;

    // One voice word at the input
    typedef struct packed {
        logic signed [15:0] sample_left;
        logic signed [15:0] sample_right;
        logic               is_mono;
        logic [7:0]         channel_volume;
        logic               positional;
        logic signed [23:0] voice_x;
        logic signed [23:0] voice_y;
        logic               layer_member;
        logic [7:0]         layer_gain;
        logic               last_voice;
    } voice_t;

    // One mixed output word
    typedef struct packed {
        logic signed [15:0] out_left;
        logic signed [15:0] out_right;
    } mix_t;

    // Listener position from the configuration registers
    typedef struct packed {
        logic signed [23:0] x;
        logic signed [23:0] y;
    } listener_t;

    // Classified voice handed from the front end to the back end
    typedef struct packed {
        logic signed [15:0] sample_left;
        logic signed [15:0] sample_right;   // already resolved for mono voices
        logic [7:0]         channel_volume;
        logic               positional;
        logic               near;           // both offsets below the range
        logic               dx_pos;         // voice right of listener: cut left
        logic [10:0]        ax;
        logic [10:0]        ay;
        logic               layer_member;
        logic [7:0]         layer_gain;
        logic               last_voice;
    } job_t;

endpackage

`default_nettype wire

@@ src/vmd_front.sv @@
// Front end: takes voice words and classifies them against the listener.
// Depends on vmd_pkg.
`default_nettype none

module vmd_front (
    input  wire logic               voice_valid,
    output logic                    voice_ready,
    input  wire vmd_pkg::voice_t    voice,
    input  wire vmd_pkg::listener_t listener,
    output logic                    job_valid,
    input  wire logic               job_ready,
    output vmd_pkg::job_t           job
);
    import vmd_pkg::*;

    logic signed [24:0] dx;
    logic signed [24:0] dy;
    logic [23:0]        ax;
    logic [23:0]        ay;

    // Offsets from the listener and their magnitudes
    always_comb
    begin
        dx = 25'(voice.voice_x) - 25'(listener.x);
        dy = 25'(voice.voice_y) - 25'(listener.y);
        ax = dx[24] ? 24'(-dx) : dx[23:0];
        ay = dy[24] ? 24'(-dy) : dy[23:0];
    end

    // Build the job word
    always_comb
    begin
        job.sample_left    = voice.sample_left;
        job.sample_right   = voice.is_mono ? voice.sample_left : voice.sample_right;
        job.channel_volume = voice.channel_volume;
        job.positional     = voice.positional;
        job.near           = (ax[23:11] == '0) && (ax[10:0] < RANGE) &&
                             (ay[23:11] == '0) && (ay[10:0] < RANGE);
        job.dx_pos         = !dx[24] && (dx != '0);
        job.ax             = ax[10:0];
        job.ay             = ay[10:0];
        job.layer_member   = voice.layer_member;
        job.layer_gain     = voice.layer_gain;
        job.last_voice     = voice.last_voice;
    end

    assign job_valid   = voice_valid;
    assign voice_ready = job_ready;

endmodule

`default_nettype wire

@@ src/vmd_queue.sv @@
// Short queue of classified jobs between the front and back ends.
// Depends on vmd_pkg.
`default_nettype none

module vmd_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push_valid,
    output logic               push_ready,
    input  wire vmd_pkg::job_t push_data,
    output logic               pop_valid,
    input  wire logic          pop_ready,
    output vmd_pkg::job_t      pop_data
);
    import vmd_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // Slot storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

@@ src/vmd_back.sv @@
// Back end: per-voice gain sequencer, stereo accumulators and frame output.
// Depends on vmd_pkg.
`default_nettype none

module vmd_back #(
    parameter int MAX_VOICES = vmd_pkg::MAX_VOICES_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          job_valid,
    output logic               job_ready,
    input  wire vmd_pkg::job_t job,
    input  wire logic [6:0]    master_volume,
    output logic               mix_valid,
    input  wire logic          mix_ready,
    output vmd_pkg::mix_t      mix
);
    import vmd_pkg::*;

    localparam int CNT_W = $clog2(MAX_VOICES + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_GAIN_MUL,
        ST_GAIN_DIV,
        ST_ACCUM,
        ST_EMIT_MUL,
        ST_EMIT_DIV,
        ST_OUTPUT
    } state_t;

    typedef enum logic [2:0] {
        GS_FAR,
        GS_FALL_L,
        GS_FALL_R,
        GS_LAYER_L,
        GS_LAYER_R
    } gain_step_t;

    state_t             state_reg;
    gain_step_t         step_reg;
    job_t               ent_reg;
    logic [7:0]         lvol_reg;
    logic [7:0]         rvol_reg;
    logic [22:0]        d2_reg;
    logic [10:0]        root_reg;
    logic [3:0]         bit_reg;
    logic [18:0]        prod_reg;
    logic signed [31:0] sum_left_reg;
    logic signed [31:0] sum_right_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               emit_side_reg;
    logic [29:0]        emit_mag_reg;
    logic               emit_neg_reg;
    logic signed [15:0] res_left_reg;
    logic signed [15:0] res_right_reg;
    mix_t               mix_reg;
    logic               mix_valid_reg;
    logic               mix_load;

    // Saturate a widened sum back to 32 bits
    function automatic logic signed [31:0] sat_sum(input logic signed [32:0] v);
        if (v[32] != v[31])
            return v[32] ? 32'sh80000000 : 32'sh7fffffff;
        return v[31:0];
    endfunction

    // Squared distance and one bit of the square root
    logic [21:0] ax_sq;
    logic [21:0] ay_sq;
    logic [22:0] d2;
    logic [10:0] trial;
    logic [21:0] trial_sq;

    always_comb
    begin
        ax_sq    = 22'(ent_reg.ax) * 22'(ent_reg.ax);
        ay_sq    = 22'(ent_reg.ay) * 22'(ent_reg.ay);
        d2       = {1'b0, ax_sq} + {1'b0, ay_sq};
        trial    = root_reg | (11'd1 << bit_reg);
        trial_sq = 22'(trial) * 22'(trial);
    end

    // Shared gain unit: (a * b) / 1500 or / 255, a product then a reciprocal
    logic [10:0] gain_a;
    logic [7:0]  gain_b;
    logic        gain_layer;
    logic [38:0] recip_prod;
    logic [7:0]  gain_q;

    always_comb
    begin
        gain_a     = RANGE - root_reg;
        gain_b     = lvol_reg;
        gain_layer = 1'b0;
        case (step_reg)
            GS_FAR:
            begin
                gain_a = RANGE - ent_reg.ax;
                gain_b = ent_reg.dx_pos ? lvol_reg : rvol_reg;
            end
            GS_FALL_L:
                gain_b = lvol_reg;
            GS_FALL_R:
                gain_b = rvol_reg;
            GS_LAYER_L:
            begin
                gain_a     = {3'b000, ent_reg.layer_gain};
                gain_layer = 1'b1;
            end
            GS_LAYER_R:
            begin
                gain_a     = {3'b000, ent_reg.layer_gain};
                gain_b     = rvol_reg;
                gain_layer = 1'b1;
            end
            default:
                gain_b = lvol_reg;
        endcase
        recip_prod = 39'(prod_reg) * 39'(gain_layer ? RECIP_255 : RECIP_RANGE);
        gain_q     = gain_layer ? recip_prod[RECIP_255_SHIFT +: 8]
                                : recip_prod[RECIP_RANGE_SHIFT +: 8];
    end

    // Accumulate the scaled samples
    logic signed [8:0]  lvol_s;
    logic signed [8:0]  rvol_s;
    logic signed [24:0] add_left;
    logic signed [24:0] add_right;
    logic signed [31:0] acc_left;
    logic signed [31:0] acc_right;

    always_comb
    begin
        lvol_s    = signed'({1'b0, lvol_reg});
        rvol_s    = signed'({1'b0, rvol_reg});
        add_left  = ent_reg.sample_left * lvol_s;
        add_right = ent_reg.sample_right * rvol_s;
        acc_left  = sat_sum(33'(sum_left_reg) + 33'(add_left));
        acc_right = sat_sum(33'(sum_right_reg) + 33'(add_right));
    end

    // Frame output: master scale, / 101 toward zero, floor / 256, clamp
    logic signed [31:0] emit_sum;
    logic [31:0]        emit_abs;
    logic [38:0]        emit_prod;
    logic [29:0]        emit_clamped;
    logic [61:0]        div_prod;
    logic [23:0]        div_q;
    logic [24:0]        rounded;
    logic [16:0]        scaled;
    logic [14:0]        out_mag;
    logic signed [15:0] emit_val;

    always_comb
    begin
        emit_sum     = emit_side_reg ? sum_right_reg : sum_left_reg;
        emit_abs     = emit_sum[31] ? unsigned'(-emit_sum) : unsigned'(emit_sum);
        emit_prod    = 39'(emit_abs) * 39'(master_volume);
        emit_clamped = (emit_prod >= 39'(EMIT_CLAMP)) ? EMIT_CLAMP : emit_prod[29:0];
        div_prod     = 62'(emit_mag_reg) * 62'(RECIP_101);
        div_q        = div_prod[RECIP_101_SHIFT +: 24];
        rounded      = emit_neg_reg ? 25'(div_q) + 25'((1 << ROUND_SHIFT) - 1) : 25'(div_q);
        scaled       = rounded[ROUND_SHIFT +: 17];
        out_mag      = (scaled > 17'(OUT_LIM)) ? OUT_LIM : scaled[14:0];
        emit_val     = emit_neg_reg ? -signed'({1'b0, out_mag}) : signed'({1'b0, out_mag});
    end

    // Output register takes a new word when empty or being drained
    assign mix_load = (state_reg == ST_OUTPUT) && (!mix_valid_reg || mix_ready);

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= GS_FAR;
            ent_reg       <= '0;
            lvol_reg      <= '0;
            rvol_reg      <= '0;
            d2_reg        <= '0;
            root_reg      <= '0;
            bit_reg       <= '0;
            prod_reg      <= '0;
            sum_left_reg  <= '0;
            sum_right_reg <= '0;
            count_reg     <= '0;
            emit_side_reg <= 1'b0;
            emit_mag_reg  <= '0;
            emit_neg_reg  <= 1'b0;
            res_left_reg  <= '0;
            res_right_reg <= '0;
            mix_reg       <= '0;
            mix_valid_reg <= 1'b0;
        end
        else
        begin
            if (mix_load)
                mix_valid_reg <= 1'b1;
            else if (mix_ready)
                mix_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (job_valid)
                    begin
                        ent_reg  <= job;
                        lvol_reg <= job.channel_volume;
                        rvol_reg <= job.channel_volume;
                        if (job.positional)
                            state_reg <= ST_SQUARE;
                        else if (job.layer_member)
                        begin
                            step_reg  <= GS_LAYER_L;
                            state_reg <= ST_GAIN_MUL;
                        end
                        else
                            state_reg <= ST_ACCUM;
                    end
                end

                // Out of range voices go silent
                ST_SQUARE:
                begin
                    d2_reg <= d2;
                    if (ent_reg.near && (d2 < RANGE_SQ))
                    begin
                        root_reg  <= '0;
                        bit_reg   <= 4'd10;
                        state_reg <= ST_ROOT;
                    end
                    else
                    begin
                        lvol_reg <= '0;
                        rvol_reg <= '0;
                        if (ent_reg.layer_member)
                        begin
                            step_reg  <= GS_LAYER_L;
                            state_reg <= ST_GAIN_MUL;
                        end
                        else
                            state_reg <= ST_ACCUM;
                    end
                end

                // One root bit per cycle, most significant first
                ST_ROOT:
                begin
                    if ({1'b0, trial_sq} <= d2_reg)
                        root_reg <= trial;
                    if (bit_reg == '0)
                    begin
                        step_reg  <= GS_FAR;
                        state_reg <= ST_GAIN_MUL;
                    end
                    else
                        bit_reg <= bit_reg - 1'b1;
                end

                ST_GAIN_MUL:
                begin
                    prod_reg  <= 19'(gain_a * gain_b);
                    state_reg <= ST_GAIN_DIV;
                end

                ST_GAIN_DIV:
                begin
                    state_reg <= ST_GAIN_MUL;
                    case (step_reg)
                        GS_FAR:
                        begin
                            if (ent_reg.dx_pos)
                                lvol_reg <= gain_q;
                            else
                                rvol_reg <= gain_q;
                            step_reg <= GS_FALL_L;
                        end
                        GS_FALL_L:
                        begin
                            lvol_reg <= gain_q;
                            step_reg <= GS_FALL_R;
                        end
                        GS_FALL_R:
                        begin
                            rvol_reg <= gain_q;
                            if (ent_reg.layer_member)
                                step_reg <= GS_LAYER_L;
                            else
                                state_reg <= ST_ACCUM;
                        end
                        GS_LAYER_L:
                        begin
                            lvol_reg <= gain_q;
                            step_reg <= GS_LAYER_R;
                        end
                        GS_LAYER_R:
                        begin
                            rvol_reg  <= gain_q;
                            state_reg <= ST_ACCUM;
                        end
                        default:
                            state_reg <= ST_ACCUM;
                    endcase
                end

                // Voices past the frame limit add nothing
                ST_ACCUM:
                begin
                    if (count_reg < CNT_W'(MAX_VOICES))
                    begin
                        sum_left_reg  <= acc_left;
                        sum_right_reg <= acc_right;
                        count_reg     <= count_reg + 1'b1;
                    end
                    if (ent_reg.last_voice)
                    begin
                        emit_side_reg <= 1'b0;
                        state_reg     <= ST_EMIT_MUL;
                    end
                    else
                        state_reg <= ST_IDLE;
                end

                ST_EMIT_MUL:
                begin
                    emit_mag_reg <= emit_clamped;
                    emit_neg_reg <= emit_sum[31];
                    state_reg    <= ST_EMIT_DIV;
                end

                ST_EMIT_DIV:
                begin
                    if (!emit_side_reg)
                    begin
                        res_left_reg  <= emit_val;
                        emit_side_reg <= 1'b1;
                        state_reg     <= ST_EMIT_MUL;
                    end
                    else
                    begin
                        res_right_reg <= emit_val;
                        state_reg     <= ST_OUTPUT;
                    end
                end

                // Hand the word to the output register and open a new frame
                ST_OUTPUT:
                begin
                    if (mix_load)
                    begin
                        mix_reg.out_left  <= res_left_reg;
                        mix_reg.out_right <= res_right_reg;
                        sum_left_reg      <= '0;
                        sum_right_reg     <= '0;
                        count_reg         <= '0;
                        state_reg         <= ST_IDLE;
                    end
                end

                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign job_ready = (state_reg == ST_IDLE);
    assign mix_valid = mix_valid_reg;
    assign mix       = mix_reg;

endmodule

`default_nettype wire

@@ src/voice_mixer_distance_pan_top.sv @@
// Voice mixer with distance pan: top level, configuration registers and wiring.
// Depends on vmd_pkg, vmd_front, vmd_queue and vmd_back.
//
// Voice words are classified against the listener position as they arrive and
// wait in a two-entry queue; a back-end sequencer then works through one voice
// at a time. A plain voice goes straight to the accumulators; a music-layer
// voice first scales its gains in the shared gain multiplier. A positional
// voice in range adds a square of the offsets, an 11-step bit-serial square
// root, then three passes of the gain multiplier; one out of range is squared
// and then silenced. The last voice of a frame is followed by scaling, division
// and clamping of both channels before the word goes to the output register.
// Configuration writes are always taken (ready stays high); index 3 is ignored.
`default_nettype none

module voice_mixer_distance_pan_top #(
    parameter int MAX_VOICES = vmd_pkg::MAX_VOICES_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           voice_valid,
    output logic                                voice_ready,
    input  wire vmd_pkg::voice_t                voice,
    output logic                                mix_valid,
    input  wire logic                           mix_ready,
    output vmd_pkg::mix_t                       mix,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [vmd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [vmd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import vmd_pkg::*;

    logic [6:0] master_volume_reg;
    listener_t  listener_reg;
    logic       job_in_valid;
    logic       job_in_ready;
    job_t       job_in;
    logic       job_out_valid;
    logic       job_out_ready;
    job_t       job_out;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            master_volume_reg <= MASTER_RESET;
            listener_reg      <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MASTER_VOLUME: master_volume_reg <= cfg_data[6:0];
                CFG_LISTENER_X:    listener_reg.x    <= signed'(cfg_data);
                CFG_LISTENER_Y:    listener_reg.y    <= signed'(cfg_data);
                default:           ;
            endcase
        end
    end

    vmd_front u_front (
        .voice_valid (voice_valid),
        .voice_ready (voice_ready),
        .voice       (voice),
        .listener    (listener_reg),
        .job_valid   (job_in_valid),
        .job_ready   (job_in_ready),
        .job         (job_in)
    );

    vmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (job_in_valid),
        .push_ready (job_in_ready),
        .push_data  (job_in),
        .pop_valid  (job_out_valid),
        .pop_ready  (job_out_ready),
        .pop_data   (job_out)
    );

    vmd_back #(
        .MAX_VOICES (MAX_VOICES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .job_valid     (job_out_valid),
        .job_ready     (job_out_ready),
        .job           (job_out),
        .master_volume (master_volume_reg),
        .mix_valid     (mix_valid),
        .mix_ready     (mix_ready),
        .mix           (mix)
    );

endmodule

`default_nettype wire

@@ src/vmd_checker.sv @@
// Port-level checks for the voice mixer, bound to the top level.
// Depends on vmd_pkg and voice_mixer_distance_pan_top.
`default_nettype none

module vmd_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            voice_valid,
    input  wire logic                            voice_ready,
    input  wire vmd_pkg::voice_t                 voice,
    input  wire logic                            mix_valid,
    input  wire logic                            mix_ready,
    input  wire vmd_pkg::mix_t                   mix,
    input  wire logic                            cfg_valid,
    input  wire logic                            cfg_ready,
    input  wire logic [vmd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [vmd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import vmd_pkg::*;

    // Frames closed at the input but not yet taken at the output
    logic [3:0] pending_reg;
    logic       frame_in;
    logic       frame_out;

    assign frame_in  = voice_valid && voice_ready && voice.last_voice;
    assign frame_out = mix_valid && mix_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else if (frame_in && !frame_out)
            pending_reg <= pending_reg + 1'b1;
        else if (frame_out && !frame_in)
            pending_reg <= pending_reg - 1'b1;
    end

    // A stalled output word holds
    a_mix_hold: assert property (@(posedge clk) disable iff (!rst_n)
        mix_valid && !mix_ready |=> mix_valid && $stable(mix))
        else $error("output word changed while stalled");

    // Every output word belongs to a frame closed earlier
    a_mix_has_frame: assert property (@(posedge clk) disable iff (!rst_n)
        mix_valid |-> pending_reg != '0)
        else $error("output word without a closed frame");

    // Clamp keeps both channels symmetric
    a_mix_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        mix_valid |-> mix.out_left != 16'sh8000 && mix.out_right != 16'sh8000)
        else $error("output sample outside the clamp range");

    // Nothing is offered while in reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !mix_valid)
        else $error("output valid during reset");

    // Configuration port never stalls
    a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready || (cfg_index != cfg_index) || (cfg_data != cfg_data))
        else $error("configuration write stalled");

endmodule

bind voice_mixer_distance_pan_top vmd_checker u_checker (.*);

`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for voice_mixer_distance_pan_top: frame mixing, distance pan and master scaling.
// Depends on vmd_pkg and the RTL under src; an internal predictor supplies the expected words.

module tb;

    import vmd_pkg::*;

    localparam longint FALLOFF_SPAN = 1500;
    localparam longint SUM_HI       = 64'sd2147483647;
    localparam longint SUM_LO       = -64'sd2147483648;
    localparam longint OUT_PEAK     = 32767;
    localparam int     VOICE_LIMIT  = MAX_VOICES_DEF;
    localparam int     SETTLE_CYC   = 40;
    localparam logic [1:0] CFG_SPARE = 2'd3;   // unmapped index, must be ignored

    logic   clk;
    logic   rst_n;
    logic   voice_valid;
    logic   voice_ready;
    voice_t voice;
    logic   mix_valid;
    logic   mix_ready;
    mix_t   mix;
    logic   cfg_valid;
    logic   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Predictor state
    int     master_q;
    longint lis_x;
    longint lis_y;
    longint sum_left;
    longint sum_right;
    int     frame_voices;
    mix_t   pending_mix[$];

    // Run control and tallies
    int send_idle_pct;
    int recv_stall_pct;
    int hold_cycles;
    int voices_sent;
    int frames_checked;
    int settings_used;
    int mismatches;

    voice_mixer_distance_pan_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .voice_valid (voice_valid),
        .voice_ready (voice_ready),
        .voice       (voice),
        .mix_valid   (mix_valid),
        .mix_ready   (mix_ready),
        .mix         (mix),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Run limit: a watchdog over a run of ~450 voices with stalls, gaps and settles
    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Saturate a running sum to 32 bit signed
    function automatic longint clip_sum(input longint acc);
        if (acc > SUM_HI)
            return SUM_HI;
        if (acc < SUM_LO)
            return SUM_LO;
        return acc;
    endfunction

    // Master scale, divide by 101 toward zero, floor by 256, clamp
    function automatic logic signed [15:0] scale_out(input longint acc);
        longint v;
        v = (acc * longint'(master_q)) / 101;
        if (v < 0)
            v = -((-v + 255) / 256);
        else
            v = v / 256;
        if (v > OUT_PEAK)
            v = OUT_PEAK;
        if (v < -OUT_PEAK)
            v = -OUT_PEAK;
        return 16'(v);
    endfunction

    // Fold one accepted voice into the frame sums; queue the mixed word on the last voice
    task automatic mix_voice(input voice_t v);
        longint left_s, right_s, left_g, right_g;
        longint dx, dy, ax, ay, d2, root_d;
        mix_t   out_w;
        left_s  = longint'($signed(v.sample_left));
        right_s = v.is_mono ? left_s : longint'($signed(v.sample_right));
        left_g  = longint'(v.channel_volume);
        right_g = left_g;
        if (v.positional)
        begin
            dx = longint'($signed(v.voice_x)) - lis_x;
            dy = longint'($signed(v.voice_y)) - lis_y;
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            d2 = ax * ax + ay * ay;
            if (d2 < FALLOFF_SPAN * FALLOFF_SPAN)
            begin
                root_d = 0;
                while ((root_d + 1) * (root_d + 1) <= d2)
                    root_d++;
                // cut the far side first, then the common falloff
                if (dx > 0)
                    left_g = ((FALLOFF_SPAN - ax) * left_g) / FALLOFF_SPAN;
                else
                    right_g = ((FALLOFF_SPAN - ax) * right_g) / FALLOFF_SPAN;
                left_g  = (left_g * (FALLOFF_SPAN - root_d)) / FALLOFF_SPAN;
                right_g = (right_g * (FALLOFF_SPAN - root_d)) / FALLOFF_SPAN;
            end
            else
            begin
                left_g  = 0;
                right_g = 0;
            end
        end
        if (v.layer_member)
        begin
            left_g  = (left_g * longint'(v.layer_gain)) / 255;
            right_g = (right_g * longint'(v.layer_gain)) / 255;
        end
        if (frame_voices < VOICE_LIMIT)
        begin
            sum_left  = clip_sum(sum_left + left_s * left_g);
            sum_right = clip_sum(sum_right + right_s * right_g);
            frame_voices++;
        end
        if (v.last_voice)
        begin
            out_w.out_left  = scale_out(sum_left);
            out_w.out_right = scale_out(sum_right);
            pending_mix.push_back(out_w);
            sum_left     = 0;
            sum_right    = 0;
            frame_voices = 0;
        end
    endtask

    // Offer one voice word, optionally after a random gap; valid stays high on return
    task automatic send_voice(input voice_t v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            voice_valid <= 1'b0;
            @(posedge clk);
        end
        voice_valid <= 1'b1;
        voice       <= v;
        @(posedge clk);
        while (!voice_ready)
            @(posedge clk);
        mix_voice(v);
        voices_sent++;
    endtask

    // Drop valid, wait for every expected word, then let the back end settle
    task automatic wait_quiet();
        voice_valid <= 1'b0;
        while (pending_mix.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // One register write; valid is left high for a following write
    task automatic write_reg(input logic [1:0] idx, input logic [23:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_MASTER_VOLUME: master_q = int'(data[6:0]);
            CFG_LISTENER_X:    lis_x = longint'($signed(data));
            CFG_LISTENER_Y:    lis_y = longint'($signed(data));
            default: ;
        endcase
    endtask

    // Load all three registers while the block is idle; upper data bits of the volume are noise
    task automatic apply_settings(input logic [6:0] vol, input logic [23:0] lx,
                                  input logic [23:0] ly);
        wait_quiet();
        write_reg(CFG_MASTER_VOLUME, {17'($urandom), vol});
        write_reg(CFG_LISTENER_X, lx);
        write_reg(CFG_LISTENER_Y, ly);
        if ($urandom_range(3) == 0)
            write_reg(CFG_SPARE, 24'($urandom));
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    function automatic voice_t make_voice(input logic signed [15:0] sl, input logic signed [15:0] sr,
                                          input bit mono, input logic [7:0] vol, input bit pos,
                                          input logic signed [23:0] x, input logic signed [23:0] y,
                                          input bit member, input logic [7:0] gain,
                                          input bit last);
        voice_t v;
        v.sample_left    = sl;
        v.sample_right   = sr;
        v.is_mono        = mono;
        v.channel_volume = vol;
        v.positional     = pos;
        v.voice_x        = x;
        v.voice_y        = y;
        v.layer_member   = member;
        v.layer_gain     = gain;
        v.last_voice     = last;
        return v;
    endfunction

    // Random voice; most positional ones land inside the audible range of the listener
    function automatic voice_t rand_voice(input bit last);
        logic [127:0] bits;
        voice_t       v;
        bits = {$urandom, $urandom, $urandom, $urandom};
        v    = bits[$bits(voice_t)-1:0];
        case ($urandom_range(7))
            0: v.sample_left = -16'sd32768;
            1: v.sample_left = 16'sd32767;
            default: ;
        endcase
        if ($urandom_range(3) == 0)
            v.channel_volume = 8'd255;
        if ($urandom_range(3) != 0)
        begin
            v.voice_x = 24'(lis_x + longint'($urandom_range(3200)) - 1600);
            v.voice_y = 24'(lis_y + longint'($urandom_range(3200)) - 1600);
        end
        v.last_voice = last;
        return v;
    endfunction

    // A frame of n random voices, the last one closing it
    task automatic send_frame(input int n);
        for (int i = 1; i <= n; i++)
            send_voice(rand_voice(i == n));
    endtask

    // Field extremes, range boundaries, pan sides, layer gain and clamping
    task automatic test_edge_voices();
        apply_settings(7'd100, 24'sd0, 24'sd0);
        send_voice(make_voice(16'sd32767, -16'sd32768, 0, 8'd255, 0, 0, 0, 0, 0, 1));
        send_voice(make_voice(-16'sd32768, 16'sd1234, 1, 8'd255, 0, 0, 0, 0, 0, 1));
        send_voice(make_voice(16'sd20000, 16'sd20000, 0, 8'd0, 0, 0, 0, 0, 0, 1));
        // on the listener, 1 unit inside the range edge on either side, exactly on it
        send_voice(make_voice(16'sd32767, 16'sd32767, 0, 8'd255, 1, 0, 0, 0, 0, 1));
        send_voice(make_voice(16'sd32767, 16'sd32767, 0, 8'd255, 1, 1499, 0, 0, 0, 1));
        send_voice(make_voice(16'sd32767, 16'sd32767, 0, 8'd255, 1, -1499, 0, 0, 0, 1));
        send_voice(make_voice(16'sd32767, 16'sd32767, 0, 8'd255, 1, 1500, 0, 0, 0, 1));
        send_voice(make_voice(16'sd32767, 16'sd32767, 0, 8'd255, 1, 900, 1200, 0, 0, 1));
        send_voice(make_voice(16'sd32767, 16'sd32767, 0, 8'd255, 1, -899, -1199, 0, 0, 1));
        send_voice(make_voice(16'sd32767, 16'sd32767, 0, 8'd255, 1, 24'sd8388607,
                              -24'sd8388608, 0, 0, 1));
        // layer gain at both ends and in the middle
        send_voice(make_voice(16'sd30000, -16'sd30000, 0, 8'd255, 0, 0, 0, 1, 8'd0, 1));
        send_voice(make_voice(16'sd30000, -16'sd30000, 0, 8'd255, 0, 0, 0, 1, 8'd255, 1));
        send_voice(make_voice(16'sd30000, -16'sd30000, 0, 8'd200, 1, 300, -400, 1, 8'd128, 1));
        // four loud voices: both outputs clamp
        for (int i = 0; i < 3; i++)
            send_voice(make_voice(16'sd32767, -16'sd32768, 0, 8'd255, 0, 0, 0, 0, 0, 0));
        send_voice(make_voice(16'sd32767, -16'sd32768, 0, 8'd255, 0, 0, 0, 0, 0, 1));
        // mono voice with a loud right sample that must be ignored
        send_voice(make_voice(-16'sd100, 16'sd32767, 1, 8'd17, 1, -50, 70, 0, 0, 1));
        wait_quiet();
    endtask

    // Master volume at zero, one and above 100; listener at both extremes
    task automatic test_settings_sweep();
        apply_settings(7'd0, 24'sd0, 24'sd0);
        send_frame(3);
        apply_settings(7'd127, 24'sd0, 24'sd0);
        send_frame(4);
        send_voice(make_voice(16'sd32767, 16'sd32767, 0, 8'd255, 0, 0, 0, 0, 0, 1));
        apply_settings(7'd1, 24'sd8388607, -24'sd8388608);
        send_frame(4);
        send_voice(make_voice(16'sd5000, 16'sd5000, 0, 8'd255, 1, -24'sd8388608,
                              24'sd8388607, 0, 0, 1));
        apply_settings(7'd100, -24'sd8388608, 24'sd8388607);
        send_frame(5);
        apply_settings(7'd64, 24'sd8388607, 24'sd8388607);
        send_frame(5);
        wait_quiet();
    endtask

    // More than MAX_VOICES voices in one frame: the excess adds nothing
    task automatic test_voice_overflow();
        apply_settings(7'd100, 24'sd0, 24'sd0);
        send_frame(VOICE_LIMIT + 6);
        send_frame(VOICE_LIMIT);
        wait_quiet();
    endtask

    // Receiver holds off long enough that the input side must stall
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 400;
        for (int i = 0; i < 24; i++)
            send_voice(rand_voice(1));
        wait_quiet();
    endtask

    // Random frames over the four idling phases, new settings for each
    task automatic test_random_frames();
        int target;
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            if ($urandom_range(1) == 0)
                apply_settings(7'($urandom_range(127)), 24'($urandom), 24'($urandom));
            else
                apply_settings(7'($urandom_range(127)), 24'($urandom_range(4000) - 2000),
                               24'($urandom_range(4000) - 2000));
            target = voices_sent + 60;
            while (voices_sent < target)
                send_frame($urandom_range(1, 8));
            wait_quiet();
        end
    endtask

    // Receiver readiness: a counted hold-off first, otherwise random stalls
    initial
    begin
        mix_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                mix_ready <= 1'b0;
                hold_cycles--;
            end
            else
                mix_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare every mixed word with the oldest expectation
    always @(posedge clk)
    begin : check_mix
        mix_t want;
        if (rst_n && mix_valid && mix_ready)
        begin
            if (pending_mix.size() == 0)
            begin
                $display("%0t: unexpected word left=%0d right=%0d", $time,
                         $signed(mix.out_left), $signed(mix.out_right));
                mismatches++;
            end
            else
            begin
                want = pending_mix.pop_front();
                frames_checked++;
                if (mix.out_left !== want.out_left)
                begin
                    $display("%0t: out_left expected %0d got %0d", $time,
                             $signed(want.out_left), $signed(mix.out_left));
                    mismatches++;
                end
                if (mix.out_right !== want.out_right)
                begin
                    $display("%0t: out_right expected %0d got %0d", $time,
                             $signed(want.out_right), $signed(mix.out_right));
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        rst_n          <= 1'b0;
        voice_valid    <= 1'b0;
        voice          <= '0;
        cfg_valid      <= 1'b0;
        cfg_index      <= '0;
        cfg_data       <= '0;
        send_idle_pct  = 25;
        recv_stall_pct = 25;
        hold_cycles    = 0;
        voices_sent    = 0;
        frames_checked = 0;
        settings_used  = 0;
        mismatches     = 0;
        master_q       = int'(MASTER_RESET);
        lis_x          = 0;
        lis_y          = 0;
        sum_left       = 0;
        sum_right      = 0;
        frame_voices   = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_edge_voices();
        test_settings_sweep();
        test_voice_overflow();
        test_backpressure();
        test_random_frames();
        wait_quiet();

        $display("Mixed %0d voices into %0d checked frames over %0d register settings,",
                 voices_sent, frames_checked, settings_used);
        $display("with range edges, voice overflow, a long output hold-off and idling phases.");
        if (mismatches == 0 && pending_mix.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
src/vmd_pkg.sv
src/vmd_front.sv
src/vmd_queue.sv
src/vmd_back.sv
src/voice_mixer_distance_pan_top.sv
src/vmd_checker.sv
sim/tb.sv
